@@ rtl/stt_pkg.sv @@
package stt_pkg;

  typedef enum logic [11:0] {
    ModeIdle    = 12'b0000_0000_0001,
    ModeBang    = 12'b0000_0000_0010,
    ModeEqual   = 12'b0000_0000_0100,
    ModeLess    = 12'b0000_0000_1000,
    ModeGreater = 12'b0000_0001_0000,
    ModeSlash   = 12'b0000_0010_0000,
    ModeComment = 12'b0000_0100_0000,
    ModeString  = 12'b0000_1000_0000,
    ModeInt     = 12'b0001_0000_0000,
    ModeDot     = 12'b0010_0000_0000,
    ModeFrac    = 12'b0100_0000_0000,
    ModeIdent   = 12'b1000_0000_0000
  } scan_mode_e;

  localparam logic [4:0] KIND_LPAREN        = 5'd0;
  localparam logic [4:0] KIND_RPAREN        = 5'd1;
  localparam logic [4:0] KIND_LBRACE        = 5'd2;
  localparam logic [4:0] KIND_RBRACE        = 5'd3;
  localparam logic [4:0] KIND_COMMA         = 5'd4;
  localparam logic [4:0] KIND_DOT           = 5'd5;
  localparam logic [4:0] KIND_MINUS         = 5'd6;
  localparam logic [4:0] KIND_PLUS          = 5'd7;
  localparam logic [4:0] KIND_SEMICOLON     = 5'd8;
  localparam logic [4:0] KIND_STAR          = 5'd9;
  localparam logic [4:0] KIND_BANG          = 5'd10;
  localparam logic [4:0] KIND_BANG_EQUAL    = 5'd11;
  localparam logic [4:0] KIND_EQUAL         = 5'd12;
  localparam logic [4:0] KIND_EQUAL_EQUAL   = 5'd13;
  localparam logic [4:0] KIND_LESS          = 5'd14;
  localparam logic [4:0] KIND_LESS_EQUAL    = 5'd15;
  localparam logic [4:0] KIND_GREATER       = 5'd16;
  localparam logic [4:0] KIND_GREATER_EQUAL = 5'd17;
  localparam logic [4:0] KIND_SLASH         = 5'd18;
  localparam logic [4:0] KIND_STRING        = 5'd19;
  localparam logic [4:0] KIND_NUMBER        = 5'd20;
  localparam logic [4:0] KIND_IDENT         = 5'd21;
  localparam logic [4:0] KIND_EOF           = 5'd22;
  localparam logic [4:0] KIND_BAD_CHAR      = 5'd23;
  localparam logic [4:0] KIND_BAD_STRING    = 5'd24;

  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  function automatic logic num_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic word_start_char(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDERSCORE);
  endfunction

endpackage

@@ rtl/source_text_tokenizer.sv @@
// Source text tokenizer.
// Input channel (in_valid_i/in_ready_o): one source byte per transfer on
// char_byte_i, or a transfer with end_of_source_i set that flushes any pending
// token and adds an end-of-file token.
// Output channel (out_valid_o/out_ready_i): one token per transfer with kind,
// lexeme start and length, line number, and last_of_run_o marking the final
// token caused by one input transfer.
// Latency: the first token of an input transfer is offered the cycle after
// that transfer. Tokens that need lookahead come out with the byte ending them.
// Throughput: one byte per cycle while each byte causes at most one token and
// the receiver takes every token. A byte causing more than one token holds off
// input while the three-entry result buffer drains them, one token per cycle
// when accepted; the next byte is taken in the cycle its last token leaves.
// Reset: scanner idle, position 0, line 1, result buffer empty.
// A stalled receiver holds the front token; input is taken again once the
// buffer is down to its last token and that token is transferred.
// Position and line counters saturate at all ones.
module source_text_tokenizer #(
  parameter int POSITION_BITS = 32,
  parameter int LINE_BITS     = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               char_byte_i,
  input  logic                     end_of_source_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [4:0]               token_kind_o,
  output logic [POSITION_BITS-1:0] lexeme_start_o,
  output logic [POSITION_BITS-1:0] lexeme_length_o,
  output logic [LINE_BITS-1:0]     line_number_o,
  output logic                     last_of_run_o
);

  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LINE_BITS-1:0]     LineOne = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0]     LineMax = '1;

  typedef struct packed {
    logic [4:0]               kind;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS-1:0] len;
    logic [LINE_BITS-1:0]     line;
    logic                     last;
  } token_t;

  stt_pkg::scan_mode_e mode_q, mode_d;
  logic [POSITION_BITS-1:0] ts_q, ts_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]     line_q, line_d;

  token_t     buf_q [3];
  token_t     new_tok [3];
  logic [1:0] cnt_q, new_cnt;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign out_valid_o = (cnt_q != 2'd0);

  assign token_kind_o    = buf_q[0].kind;
  assign lexeme_start_o  = buf_q[0].start;
  assign lexeme_length_o = buf_q[0].len;
  assign line_number_o   = buf_q[0].line;
  assign last_of_run_o   = buf_q[0].last;

  // scan of a byte with no token pending
  logic                f_emit, f_set_start, f_nl;
  logic [4:0]          f_kind;
  stt_pkg::scan_mode_e f_mode;

  always_comb begin
    f_emit      = 1'b1;
    f_set_start = 1'b0;
    f_nl        = 1'b0;
    f_kind      = stt_pkg::KIND_BAD_CHAR;
    f_mode      = stt_pkg::ModeIdle;
    case (char_byte_i)
      stt_pkg::CH_LPAREN:    f_kind = stt_pkg::KIND_LPAREN;
      stt_pkg::CH_RPAREN:    f_kind = stt_pkg::KIND_RPAREN;
      stt_pkg::CH_LBRACE:    f_kind = stt_pkg::KIND_LBRACE;
      stt_pkg::CH_RBRACE:    f_kind = stt_pkg::KIND_RBRACE;
      stt_pkg::CH_COMMA:     f_kind = stt_pkg::KIND_COMMA;
      stt_pkg::CH_DOT:       f_kind = stt_pkg::KIND_DOT;
      stt_pkg::CH_MINUS:     f_kind = stt_pkg::KIND_MINUS;
      stt_pkg::CH_PLUS:      f_kind = stt_pkg::KIND_PLUS;
      stt_pkg::CH_SEMICOLON: f_kind = stt_pkg::KIND_SEMICOLON;
      stt_pkg::CH_STAR:      f_kind = stt_pkg::KIND_STAR;
      stt_pkg::CH_BANG: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeBang;
      end
      stt_pkg::CH_EQUAL: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeEqual;
      end
      stt_pkg::CH_LESS: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeLess;
      end
      stt_pkg::CH_GREATER: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeGreater;
      end
      stt_pkg::CH_SLASH: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeSlash;
      end
      stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR: f_emit = 1'b0;
      stt_pkg::CH_NEWLINE: begin
        f_emit = 1'b0; f_nl = 1'b1;
      end
      stt_pkg::CH_QUOTE: begin
        f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeString;
      end
      default: begin
        if (stt_pkg::num_char(char_byte_i)) begin
          f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeInt;
        end else if (stt_pkg::word_start_char(char_byte_i)) begin
          f_emit = 1'b0; f_set_start = 1'b1; f_mode = stt_pkg::ModeIdent;
        end
      end
    endcase
  end

  // spans of the pending token
  logic [POSITION_BITS-1:0] span_len, str_start, str_len, dot_pos;
  logic                     ts_before;
  assign ts_before = pos_q > ts_q;
  assign span_len  = pos_q - ts_q;
  assign str_start = (ts_q != PosMax) ? ts_q + PosOne : PosMax;
  assign str_len   = ts_before ? span_len - PosOne : '0;
  assign dot_pos   = ts_before ? pos_q - PosOne : ts_q;

  logic [4:0] op_kind;
  always_comb begin
    case (mode_q)
      stt_pkg::ModeBang:  op_kind = stt_pkg::KIND_BANG;
      stt_pkg::ModeEqual: op_kind = stt_pkg::KIND_EQUAL;
      stt_pkg::ModeLess:  op_kind = stt_pkg::KIND_LESS;
      default:            op_kind = stt_pkg::KIND_GREATER;
    endcase
  end

  // slot a: pending token, slot b: dot after a number, slot c: fresh or eof
  logic   a_v, b_v, c_v, use_fresh, nl;
  token_t a_tok, b_tok, c_tok;
  logic   is_dig, is_aln;
  assign is_dig = stt_pkg::num_char(char_byte_i);
  assign is_aln = is_dig || stt_pkg::word_start_char(char_byte_i);

  always_comb begin
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    use_fresh = 1'b0;
    nl        = 1'b0;
    mode_d    = mode_q;
    ts_d      = ts_q;
    a_tok     = '{kind: op_kind, start: ts_q, len: span_len, line: line_q, last: 1'b0};
    b_tok     = '{kind: stt_pkg::KIND_DOT, start: dot_pos, len: PosOne, line: line_q,
                  last: 1'b0};
    c_tok     = '{kind: f_kind, start: pos_q, len: PosOne, line: line_q, last: 1'b0};
    if (end_of_source_i) begin
      case (mode_q)
        stt_pkg::ModeBang, stt_pkg::ModeEqual, stt_pkg::ModeLess,
        stt_pkg::ModeGreater: a_v = 1'b1;
        stt_pkg::ModeSlash: begin
          a_v = 1'b1; a_tok.kind = stt_pkg::KIND_SLASH;
        end
        stt_pkg::ModeString: begin
          a_v = 1'b1; a_tok.kind = stt_pkg::KIND_BAD_STRING;
          a_tok.start = str_start; a_tok.len = str_len;
        end
        stt_pkg::ModeInt, stt_pkg::ModeFrac: begin
          a_v = 1'b1; a_tok.kind = stt_pkg::KIND_NUMBER;
        end
        stt_pkg::ModeDot: begin
          a_v = 1'b1; b_v = 1'b1; a_tok.kind = stt_pkg::KIND_NUMBER;
          a_tok.len = dot_pos - ts_q;
        end
        stt_pkg::ModeIdent: begin
          a_v = 1'b1; a_tok.kind = stt_pkg::KIND_IDENT;
        end
        default: ;
      endcase
      c_v        = 1'b1;
      c_tok.kind = stt_pkg::KIND_EOF;
      c_tok.len  = '0;
      mode_d     = stt_pkg::ModeIdle;
    end else begin
      case (mode_q)
        stt_pkg::ModeBang, stt_pkg::ModeEqual, stt_pkg::ModeLess,
        stt_pkg::ModeGreater: begin
          a_v = 1'b1;
          if (char_byte_i == stt_pkg::CH_EQUAL) begin
            a_tok.kind = op_kind + 5'd1;
            a_tok.len  = span_len + PosOne;
            mode_d     = stt_pkg::ModeIdle;
          end else begin
            use_fresh = 1'b1;
          end
        end
        stt_pkg::ModeSlash: begin
          if (char_byte_i == stt_pkg::CH_SLASH) begin
            mode_d = stt_pkg::ModeComment;
          end else begin
            a_v = 1'b1; a_tok.kind = stt_pkg::KIND_SLASH; use_fresh = 1'b1;
          end
        end
        stt_pkg::ModeComment: use_fresh = (char_byte_i == stt_pkg::CH_NEWLINE);
        stt_pkg::ModeString: begin
          if (char_byte_i == stt_pkg::CH_QUOTE) begin
            a_v = 1'b1; a_tok.kind = stt_pkg::KIND_STRING;
            a_tok.start = str_start; a_tok.len = str_len;
            mode_d = stt_pkg::ModeIdle;
          end else if (char_byte_i == stt_pkg::CH_NEWLINE) begin
            nl = 1'b1;
          end
        end
        stt_pkg::ModeInt: begin
          if (char_byte_i == stt_pkg::CH_DOT) begin
            mode_d = stt_pkg::ModeDot;
          end else if (!is_dig) begin
            a_v = 1'b1; a_tok.kind = stt_pkg::KIND_NUMBER; use_fresh = 1'b1;
          end
        end
        stt_pkg::ModeDot: begin
          if (is_dig) begin
            mode_d = stt_pkg::ModeFrac;
          end else begin
            a_v = 1'b1; b_v = 1'b1; a_tok.kind = stt_pkg::KIND_NUMBER;
            a_tok.len = dot_pos - ts_q; use_fresh = 1'b1;
          end
        end
        stt_pkg::ModeFrac: begin
          if (!is_dig) begin
            a_v = 1'b1; a_tok.kind = stt_pkg::KIND_NUMBER; use_fresh = 1'b1;
          end
        end
        stt_pkg::ModeIdent: begin
          if (!is_aln) begin
            a_v = 1'b1; a_tok.kind = stt_pkg::KIND_IDENT; use_fresh = 1'b1;
          end
        end
        default: use_fresh = 1'b1;
      endcase
      if (use_fresh) begin
        mode_d = f_mode;
        c_v    = f_emit;
        nl     = f_nl;
        if (f_set_start) ts_d = pos_q;
      end
    end
  end

  assign pos_d  = (!end_of_source_i && (pos_q != PosMax)) ? pos_q + PosOne : pos_q;
  assign line_d = (nl && (line_q != LineMax)) ? line_q + LineOne : line_q;

  // pack slots in order; b is only set together with a
  always_comb begin
    new_cnt    = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    new_tok[0] = a_v ? a_tok : c_tok;
    new_tok[1] = b_v ? b_tok : c_tok;
    new_tok[2] = c_tok;
    new_tok[0].last = (new_cnt == 2'd1);
    new_tok[1].last = (new_cnt == 2'd2);
    new_tok[2].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::ModeIdle;
      ts_q   <= '0;
      pos_q  <= '0;
      line_q <= LineOne;
      cnt_q  <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_q <= mode_d;
        ts_q   <= ts_d;
        pos_q  <= pos_d;
        line_q <= line_d;
        cnt_q  <= new_cnt;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q[0] <= new_tok[0];
      buf_q[1] <= new_tok[1];
      buf_q[2] <= new_tok[2];
    end else if (out_fire) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

`ifndef SYNTHESIS
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !end_of_source_i |=>
      ($past(pos_q) == PosMax) || (pos_q == $past(pos_q) + PosOne))
    else $error("position did not advance on a byte");

  a_eos_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_source_i |=> out_valid_o && (mode_q == stt_pkg::ModeIdle))
    else $error("end of source gave no token or left scanner busy");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> buf_q[0].last)
    else $error("final buffered token not marked last");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count wrapped to zero");
`endif

endmodule
